/* src/esmd_pkg.sv */
`timescale 1ns / 1ps
package esmd_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_END       = 4'd1,
    ST_PCRC      = 4'd2,
    ST_MCRC      = 4'd3,
    ST_SHORT     = 4'd4,
    ST_HLEN      = 4'd5,
    ST_VTYPE     = 4'd6,
    ST_NO_MT     = 4'd7,
    ST_UNK_MT    = 4'd8,
    ST_UNK_EV    = 4'd9,
    ST_SRV_ERR   = 4'd10,
    ST_TRUNC     = 4'd11
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pbyte;
    logic [1:0] ek;
    logic       lp;
    logic [3:0] status;
    logic       done;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] name_mt_chr(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = ":";  4'd1: r = "m";  4'd2: r = "e";  4'd3: r = "s";
      4'd4: r = "s";  4'd5: r = "a";  4'd6: r = "g";  4'd7: r = "e";
      4'd8: r = "-";  4'd9: r = "t";  4'd10: r = "y"; 4'd11: r = "p";
      4'd12: r = "e";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] name_et_chr(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = ":";  4'd1: r = "e";  4'd2: r = "v";  4'd3: r = "e";
      4'd4: r = "n";  4'd5: r = "t";  4'd6: r = "-";  4'd7: r = "t";
      4'd8: r = "y";  4'd9: r = "p";  4'd10: r = "e";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] val_chr(input logic [2:0] v, input logic [2:0] i);
    logic [63:0] s;
    case (v)
      3'd0: s = {"event", 24'd0};
      3'd1: s = {"error", 24'd0};
      3'd2: s = {"Records", 8'd0};
      3'd3: s = "Progress";
      3'd4: s = {"Stats", 24'd0};
      3'd5: s = {"Cont", 32'd0};
      3'd6: s = {"End", 40'd0};
      default: s = 64'd0;
    endcase
    return s[63 - 8*i -: 8];
  endfunction

  function automatic logic [3:0] val_len(input logic [2:0] v);
    logic [3:0] r;
    case (v)
      3'd0, 3'd1, 3'd4: r = 4'd5;
      3'd2: r = 4'd7;
      3'd3: r = 4'd8;
      3'd5: r = 4'd4;
      3'd6: r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/esmd_front.sv */
`timescale 1ns / 1ps
module esmd_front
  import esmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_body_end,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res_data
);

  typedef enum logic [4:0] {
    PH_PRELUDE = 5'b00001,
    PH_HEADERS = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_MCRC    = 5'b01000,
    PH_DRAIN   = 5'b10000
  } phase_t;

  typedef enum logic [5:0] {
    SUB_NLEN = 6'b000001,
    SUB_NAME = 6'b000010,
    SUB_TYPE = 6'b000100,
    SUB_VLHI = 6'b001000,
    SUB_VLLO = 6'b010000,
    SUB_VAL  = 6'b100000
  } hsub_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] hlen_r, hlen_nxt;
  logic [31:0] pcrc_r, pcrc_nxt;
  logic [31:0] mcrc_r, mcrc_nxt;
  logic [31:0] ws_r, ws_nxt;
  hsub_t       sub_r, sub_nxt;
  logic [15:0] fc_r, fc_nxt;
  logic [10:0] mf_r, mf_nxt;
  logic [1:0]  mt_r, mt_nxt;
  logic [2:0]  et_r, et_nxt;
  logic        emit;
  result_t     res;
  logic        fire;

  assign in_ready  = res_ready;
  assign fire      = in_valid && in_ready;
  assign res_valid = fire && emit;
  assign res_data  = res;

  always_comb begin
    logic [7:0]  b;
    logic        fatal, msgend, hst_v;
    logic [3:0]  hst;
    logic [10:0] oldf;
    logic [15:0] fcn;
    logic [31:0] wsv;
    b = in_data_byte;
    phase_nxt = phase_r; off_nxt = off_r; total_nxt = total_r; hlen_nxt = hlen_r;
    pcrc_nxt = pcrc_r; mcrc_nxt = mcrc_r; ws_nxt = ws_r; sub_nxt = sub_r;
    fc_nxt = fc_r; mf_nxt = mf_r; mt_nxt = mt_r; et_nxt = et_r;
    emit = 1'b0; res = '0; fatal = 1'b0; msgend = 1'b0; hst_v = 1'b0; hst = ST_OK;
    oldf = '0; fcn = '0; wsv = '0;
    if (phase_r == PH_DRAIN) begin
      if (in_body_end) begin
        phase_nxt = PH_PRELUDE; off_nxt = '0; pcrc_nxt = '1; mcrc_nxt = '1; ws_nxt = '0;
        total_nxt = '0; hlen_nxt = '0; sub_nxt = SUB_NLEN; fc_nxt = '0; mf_nxt = '0;
        mt_nxt = '0; et_nxt = '0;
      end
    end else begin
      if (phase_r != PH_MCRC) mcrc_nxt = crc_byte(mcrc_r, b);
      case (phase_r)
        PH_PRELUDE: begin
          if (off_r < 32'd8) pcrc_nxt = crc_byte(pcrc_r, b);
          ws_nxt = {ws_r[23:0], b};
          if (off_r == 32'd3) begin
            total_nxt = ws_nxt;
            if (ws_nxt < 32'd56) begin
              emit = 1'b1; res.kind = 1'b1; res.status = ST_SHORT; fatal = 1'b1;
            end
          end else if (off_r == 32'd7) begin
            hlen_nxt = ws_nxt;
            if (ws_nxt < 32'd40 || ws_nxt > total_r - 32'd16) begin
              emit = 1'b1; res.kind = 1'b1; res.status = ST_HLEN; fatal = 1'b1;
            end
          end else if (off_r == 32'd11) begin
            if (ws_nxt != ~pcrc_r) begin
              emit = 1'b1; res.kind = 1'b1; res.status = ST_PCRC; fatal = 1'b1;
            end else begin
              phase_nxt = PH_HEADERS; sub_nxt = SUB_NLEN; fc_nxt = '0; mf_nxt = '0;
              mt_nxt = '0; et_nxt = '0;
            end
          end
        end
        PH_HEADERS: begin
          case (sub_r)
            SUB_NLEN: begin
              ws_nxt = {24'd0, b}; fc_nxt = '0; mf_nxt = '0;
              mf_nxt[0] = (b == 8'd13);
              mf_nxt[1] = (b == 8'd11);
              sub_nxt = (b != 8'd0) ? SUB_NAME : SUB_TYPE;
            end
            SUB_NAME: begin
              if (mf_r[0] && fc_r < 16'd13 && b != name_mt_chr(fc_r[3:0])) mf_nxt[0] = 1'b0;
              if (mf_r[1] && fc_r < 16'd11 && b != name_et_chr(fc_r[3:0])) mf_nxt[1] = 1'b0;
              fcn = fc_r + 16'd1;
              fc_nxt = fcn;
              if ({16'd0, fcn} >= ws_r) sub_nxt = SUB_TYPE;
            end
            SUB_TYPE: begin
              if (b != 8'd7) begin
                hst_v = 1'b1; hst = ST_VTYPE;
              end else sub_nxt = SUB_VLHI;
            end
            SUB_VLHI: begin
              ws_nxt = {24'd0, b}; sub_nxt = SUB_VLLO;
            end
            default: begin
              if (sub_r == SUB_VLLO) begin
                wsv = {16'd0, ws_r[7:0], b};
                ws_nxt = wsv; fc_nxt = '0; oldf = mf_r; mf_nxt = '0;
                if (oldf[0] && mt_r == 2'd0) begin
                  mf_nxt[2] = 1'b1;
                  for (int v = 0; v < 2; v++)
                    if (wsv == {28'd0, val_len(3'(v))}) mf_nxt[4+v] = 1'b1;
                end
                if (oldf[1] && et_r == 3'd0) begin
                  mf_nxt[3] = 1'b1;
                  for (int v = 2; v < 7; v++)
                    if (wsv == {28'd0, val_len(3'(v))}) mf_nxt[4+v] = 1'b1;
                end
                sub_nxt = SUB_VAL;
              end else begin
                wsv = ws_r;
                mf_nxt = mf_r;
                for (int v = 0; v < 7; v++)
                  if (mf_r[4+v] && (fc_r >= {12'd0, val_len(3'(v))} ||
                      b != val_chr(3'(v), fc_r[2:0])))
                    mf_nxt[4+v] = 1'b0;
                fcn = fc_r + 16'd1;
                fc_nxt = fcn;
              end
              if ((sub_r == SUB_VLLO && wsv == 32'd0) ||
                  (sub_r != SUB_VLLO && {16'd0, fcn} >= wsv)) begin
                if (mf_nxt[2]) begin
                  mt_nxt = 2'd3;
                  if (mf_nxt[4]) mt_nxt = 2'd1;
                  else if (mf_nxt[5]) mt_nxt = 2'd2;
                end
                if (mf_nxt[3]) begin
                  et_nxt = 3'd6;
                  for (int v = 6; v >= 2; v--)
                    if (mf_nxt[4+v]) et_nxt = 3'(v - 1);
                end
                mf_nxt = '0; sub_nxt = SUB_NLEN;
              end
            end
          endcase
          if (hst_v) begin
            emit = 1'b1; res.kind = 1'b1; res.status = hst; fatal = 1'b1;
          end else if (off_r == 32'd11 + hlen_r) begin
            hst_v = 1'b1;
            if (sub_nxt != SUB_NLEN) hst = ST_HLEN;
            else if (mt_nxt == 2'd0) hst = ST_NO_MT;
            else if (mt_nxt == 2'd3) hst = ST_UNK_MT;
            else if (mt_nxt == 2'd2) hst = ST_SRV_ERR;
            else if (et_nxt == 3'd0 || et_nxt == 3'd6) hst = ST_UNK_EV;
            else hst_v = 1'b0;
            if (hst_v) begin
              emit = 1'b1; res.kind = 1'b1; res.status = hst; fatal = 1'b1;
            end else phase_nxt = (total_r - hlen_r - 32'd16 != 32'd0) ? PH_PAYLOAD : PH_MCRC;
          end
        end
        PH_PAYLOAD: begin
          if (et_r >= 3'd1 && et_r <= 3'd3) begin
            emit = 1'b1; res.pbyte = b; res.ek = 2'(et_r - 3'd1);
            res.lp = (off_r == total_r - 32'd5);
          end
          if (off_r == total_r - 32'd5) phase_nxt = PH_MCRC;
        end
        default: begin
          ws_nxt = {ws_r[23:0], b};
          if (off_r == total_r - 32'd1) begin
            emit = 1'b1; res.kind = 1'b1;
            if (ws_nxt != ~mcrc_r) begin
              res.status = ST_MCRC; fatal = 1'b1;
            end else if (et_r == 3'd5) begin
              res.status = ST_END; fatal = 1'b1;
            end else begin
              res.status = ST_OK; msgend = 1'b1;
            end
          end
        end
      endcase
      if (in_body_end) begin
        if (!(emit && res.kind)) begin
          res = '0; res.kind = 1'b1; res.status = ST_TRUNC;
        end
        emit = 1'b1; res.done = 1'b1;
        phase_nxt = PH_PRELUDE; off_nxt = '0; pcrc_nxt = '1; mcrc_nxt = '1; ws_nxt = '0;
        total_nxt = '0; hlen_nxt = '0; sub_nxt = SUB_NLEN; fc_nxt = '0; mf_nxt = '0;
        mt_nxt = '0; et_nxt = '0;
      end else if (fatal) begin
        res.done = 1'b1; phase_nxt = PH_DRAIN;
      end else if (msgend) begin
        phase_nxt = PH_PRELUDE; off_nxt = '0; pcrc_nxt = '1; mcrc_nxt = '1; ws_nxt = '0;
      end else begin
        off_nxt = off_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRELUDE; off_r <= '0; total_r <= '0; hlen_r <= '0;
      pcrc_r <= '1; mcrc_r <= '1; ws_r <= '0; sub_r <= SUB_NLEN;
      fc_r <= '0; mf_r <= '0; mt_r <= '0; et_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt; off_r <= off_nxt; total_r <= total_nxt; hlen_r <= hlen_nxt;
      pcrc_r <= pcrc_nxt; mcrc_r <= mcrc_nxt; ws_r <= ws_nxt; sub_r <= sub_nxt;
      fc_r <= fc_nxt; mf_r <= mf_nxt; mt_r <= mt_nxt; et_r <= et_nxt;
    end
  end

endmodule

/* src/esmd_queue.sv */
`timescale 1ns / 1ps
module esmd_queue
  import esmd_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  result_t wr_data,
  output logic    rd_valid,
  input  logic    rd_ready,
  output result_t rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  result_t       mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr, rd;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

/* src/event_stream_message_deframer_top.sv */
`timescale 1ns / 1ps
// Channel  Ports                                              Direction
// in       in_valid in_ready in_data_byte in_body_end          sink
// out      out_valid out_ready out_item_kind out_payload_byte  source
//          out_event_kind out_last_payload out_status_code out_body_done
// One byte per cycle while the queue has room; the per-byte CRC and parse step of the front decoder sets it.
// A result is written into a DEPTH-entry queue as its byte is taken, and reaches out from the queue head.
// in_ready drops only while that queue is full; out stalls never lose a beat.
// rst_n is synchronous; after reset the block waits for the first prelude byte.
module event_stream_message_deframer_top
  import esmd_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_body_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_item_kind,
  output logic [7:0] out_payload_byte,
  output logic [1:0] out_event_kind,
  output logic       out_last_payload,
  output logic [3:0] out_status_code,
  output logic       out_body_done
);

  logic    res_valid, res_ready;
  result_t res_data, q_data;

  esmd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_body_end,
    .res_valid, .res_ready, .res_data
  );

  esmd_queue #(.DEPTH(DEPTH)) u_queue (
    .clk, .rst_n, .wr_valid(res_valid), .wr_ready(res_ready), .wr_data(res_data),
    .rd_valid(out_valid), .rd_ready(out_ready), .rd_data(q_data)
  );

  assign out_item_kind    = q_data.kind;
  assign out_payload_byte = q_data.pbyte;
  assign out_event_kind   = q_data.ek;
  assign out_last_payload = q_data.lp;
  assign out_status_code  = q_data.status;
  assign out_body_done    = q_data.done;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(q_data))
    else $error("out beat changed while stalled");
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_kind |-> !out_body_done && out_status_code == ST_OK)
    else $error("payload beat carries status");
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind |-> out_payload_byte == 8'd0 && !out_last_payload)
    else $error("status beat carries payload");
`endif

endmodule
